// ----- rtl/bal_pkg.sv -----
// shared types and constants for the bounded array list
// no dependencies; compiled first
package bal_pkg;

  localparam int       DEPTH_DEFAULT = 16;
  localparam logic [4:0] CAP_RESET   = 5'd16;

  typedef enum logic [2:0] {
    CMD_APPEND  = 3'd0,
    CMD_INSERT  = 3'd1,
    CMD_REM_IDX = 3'd2,
    CMD_REM_VAL = 3'd3,
    CMD_READ    = 3'd4
  } cmd_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic walk;
    logic put;
    logic finish;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic need_walk;
    logic need_put;
    logic walk_last;
  } stat_t;

  typedef struct packed {
    logic               done_res;
    logic [3:0]         entry_index;
    logic signed [31:0] read_word;
    logic [4:0]         removed;
    logic [4:0]         length;
    logic               is_full;
    logic               is_empty;
  } res_t;

endpackage

// ----- rtl/bal_if.sv -----
// channel interfaces of the bounded array list: command, result, configuration
// no dependencies
interface bal_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [7:0]         position;
  logic signed [31:0] value;
  modport source (output valid, command, position, value, input ready);
  modport sink   (input valid, command, position, value, output ready);
endinterface

interface bal_res_if;
  logic               valid;
  logic               ready;
  logic               done_res;
  logic [3:0]         entry_index;
  logic signed [31:0] read_word;
  logic [4:0]         removed;
  logic [4:0]         length;
  logic               is_full;
  logic               is_empty;
  modport source (output valid, done_res, entry_index, read_word, removed, length,
                  is_full, is_empty, input ready);
  modport sink   (input valid, done_res, entry_index, read_word, removed, length,
                  is_full, is_empty, output ready);
endinterface

interface bal_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] capacity;
  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

// ----- rtl/bal_ctrl.sv -----
// sequencing state machine of the bounded array list
// depends on bal_pkg
module bal_ctrl import bal_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output ctl_t  ctl_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ROUTE = 6'b000010,
    S_WALK  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_PUT   = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.accept = 1'b1;
          state_d      = S_ROUTE;
        end
      end
      S_ROUTE: begin
        if (stat_i.need_walk) state_d = S_WALK;
        else if (stat_i.need_put) state_d = S_PUT;
        else state_d = S_DONE;
      end
      S_WALK: begin
        ctl_o.walk = 1'b1;
        if (stat_i.walk_last) state_d = S_DRAIN;
      end
      // last read returns and is written back
      S_DRAIN: begin
        state_d = stat_i.need_put ? S_PUT : S_DONE;
      end
      S_PUT: begin
        ctl_o.put = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          ctl_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (ctl_o.finish) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/bal_dp.sv -----
// datapath of the bounded array list: entry memory, count, walk pointers, result register
// depends on bal_pkg
module bal_dp import bal_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [2:0]         command_i,
  input  logic [7:0]         position_i,
  input  logic signed [31:0] value_i,
  input  logic               cfg_we_i,
  input  logic [4:0]         cfg_cap_i,
  input  ctl_t               ctl_i,
  output stat_t              stat_o,
  output res_t               res_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 8) ? CW : 8;
  localparam int EW = (CW > 5) ? CW : 5;

  logic signed [31:0] mem_q [DEPTH];

  cmd_e               cmd_q;
  logic signed [31:0] val_q, rdata_q, rword_q;
  logic [CW-1:0]      cnt_q, keep_q, rem_q;
  logic [4:0]         cap_q;
  logic               ok_q, down_q, need_walk_q, need_put_q, rd_vld_q;
  logic [AW-1:0]      at_q, rp_q, end_q, rd_addr_q;
  res_t               res_q;

  // effective capacity, clamped to 1..DEPTH
  logic [EW-1:0] cap_w, eff_cap;
  always_comb begin
    cap_w = EW'(cap_q);
    if (cap_w == '0) eff_cap = EW'(1);
    else if (cap_w > EW'(DEPTH)) eff_cap = EW'(DEPTH);
    else eff_cap = cap_w;
  end

  // plan of a new command
  logic [PW-1:0] pos_w, cnt_w;
  logic          pos_in, room;
  logic [AW-1:0] pos_a, cnt_a, last_a;
  logic          p_ok, p_walk, p_put, p_down;
  logic [AW-1:0] p_at, p_start, p_end;

  always_comb begin
    pos_w   = PW'(position_i);
    cnt_w   = PW'(cnt_q);
    pos_in  = pos_w < cnt_w;
    room    = EW'(cnt_q) < eff_cap;
    pos_a   = AW'(position_i);
    cnt_a   = AW'(cnt_q);
    last_a  = AW'(cnt_q - CW'(1));
    p_ok    = 1'b0;
    p_walk  = 1'b0;
    p_put   = 1'b0;
    p_down  = 1'b0;
    p_at    = cnt_a;
    p_start = '0;
    p_end   = '0;
    unique case (command_i)
      CMD_APPEND: begin
        p_ok  = room;
        p_put = room;
      end
      CMD_INSERT: begin
        p_ok  = room;
        p_put = room;
        if (pos_in) begin
          p_at    = pos_a;
          p_walk  = room;
          p_start = last_a;
          p_end   = pos_a;
          p_down  = 1'b1;
        end
      end
      CMD_REM_IDX: begin
        p_ok    = pos_in;
        p_walk  = pos_in && ((cnt_w - pos_w) > PW'(1));
        p_start = pos_a + AW'(1);
        p_end   = last_a;
      end
      CMD_REM_VAL: begin
        p_walk = cnt_q != '0;
        p_end  = last_a;
      end
      CMD_READ: begin
        p_ok    = pos_in;
        p_walk  = pos_in;
        p_start = pos_a;
        p_end   = pos_a;
      end
      default: p_ok = 1'b0;
    endcase
  end

  // write port: final put or write-back of returned read data
  logic               we;
  logic [AW-1:0]      wa;
  logic signed [31:0] wd;
  logic               hit;

  always_comb begin
    we  = 1'b0;
    wa  = at_q;
    wd  = val_q;
    hit = rdata_q == val_q;
    if (ctl_i.put) begin
      we = 1'b1;
    end else if (rd_vld_q) begin
      wd = rdata_q;
      case (cmd_q)
        CMD_INSERT: begin
          we = 1'b1;
          wa = rd_addr_q + AW'(1);
        end
        CMD_REM_IDX: begin
          we = 1'b1;
          wa = rd_addr_q - AW'(1);
        end
        CMD_REM_VAL: begin
          we = !hit;
          wa = AW'(keep_q);
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    if (ctl_i.walk) rdata_q <= mem_q[rp_q];
  end

  // result of the finished command
  logic [CW-1:0] new_cnt;
  res_t          res_d;
  always_comb begin
    case (cmd_q)
      CMD_APPEND, CMD_INSERT: new_cnt = ok_q ? cnt_q + CW'(1) : cnt_q;
      CMD_REM_IDX:            new_cnt = ok_q ? cnt_q - CW'(1) : cnt_q;
      CMD_REM_VAL:            new_cnt = keep_q;
      default:                new_cnt = cnt_q;
    endcase
    res_d.done_res    = (cmd_q == CMD_REM_VAL) ? (rem_q != '0) : ok_q;
    res_d.entry_index = ((cmd_q == CMD_APPEND || cmd_q == CMD_INSERT) && ok_q) ?
                        4'(at_q) : 4'd0;
    res_d.read_word   = rword_q;
    if (cmd_q == CMD_REM_VAL) res_d.removed = 5'(rem_q);
    else if (cmd_q == CMD_REM_IDX && ok_q) res_d.removed = 5'd1;
    else res_d.removed = 5'd0;
    res_d.length   = 5'(new_cnt);
    res_d.is_full  = EW'(new_cnt) >= eff_cap;
    res_d.is_empty = new_cnt == '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      cap_q    <= CAP_RESET;
      rd_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_cap_i;
      if (ctl_i.finish) cnt_q <= new_cnt;
      rd_vld_q <= ctl_i.walk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      cmd_q       <= cmd_e'(command_i);
      val_q       <= value_i;
      ok_q        <= p_ok;
      at_q        <= p_at;
      rp_q        <= p_start;
      end_q       <= p_end;
      down_q      <= p_down;
      need_walk_q <= p_walk;
      need_put_q  <= p_put;
      keep_q      <= '0;
      rem_q       <= '0;
      rword_q     <= '0;
    end else begin
      if (ctl_i.walk) begin
        rp_q      <= down_q ? rp_q - AW'(1) : rp_q + AW'(1);
      end
      if (rd_vld_q) begin
        if (cmd_q == CMD_REM_VAL) begin
          if (hit) rem_q <= rem_q + CW'(1);
          else keep_q <= keep_q + CW'(1);
        end
        if (cmd_q == CMD_READ) rword_q <= rdata_q;
      end
    end
    rd_addr_q <= rp_q;
    if (ctl_i.finish) res_q <= res_d;
  end

  assign stat_o.need_walk = need_walk_q;
  assign stat_o.need_put  = need_put_q;
  assign stat_o.walk_last = rp_q == end_q;
  assign res_o            = res_q;

endmodule

// ----- rtl/bounded_array_list.sv -----
// top level of the bounded array list: controller, datapath and channel wiring
// depends on bal_pkg, bal_if, bal_ctrl, bal_dp
//
// bounded array list: keeps an ordered list of up to DEPTH signed 32-bit words
// together with an entry count, and takes one command per request on in_i:
// append, insert at an index, remove at an index, remove every entry equal to a
// value, and read. every request yields one result on res_o, carrying the done
// flag, the index where a word was placed, the word read, the number of entries
// removed, the new length and the full and empty flags. the capacity register is
// written over cfg_i; it clamps to 1..DEPTH, and a capacity below the current
// length drops nothing but refuses further adds. requests are handled one at a
// time; each is accepted, routed, then walks the entries it moves or reads, drains
// the last read, puts the new word and finishes, skipping the steps it does not
// need. the entry memory has one read and one write port and moves one entry per
// cycle during the walk. one finished result may wait in the output register
// while the next request is accepted; that request then holds in its last cycle
// until the waiting result is taken. the entry memory needs no clearing after
// reset, since only entries below the count are read.
module bounded_array_list import bal_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bal_cmd_if.sink   in_i,
  bal_res_if.source res_o,
  bal_cfg_if.sink   cfg_i
);

  ctl_t  ctl;
  stat_t stat;
  res_t  res;

  // configuration is always taken; the user must write it only while idle, the block does not enforce this
  assign cfg_i.ready = 1'b1;

  bal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  bal_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .command_i  (in_i.command),
    .position_i (in_i.position),
    .value_i    (in_i.value),
    .cfg_we_i   (cfg_i.valid),
    .cfg_cap_i  (cfg_i.capacity),
    .ctl_i      (ctl),
    .stat_o     (stat),
    .res_o      (res)
  );

  // result payload straight from the output register
  assign res_o.done_res    = res.done_res;
  assign res_o.entry_index = res.entry_index;
  assign res_o.read_word   = res.read_word;
  assign res_o.removed     = res.removed;
  assign res_o.length      = res.length;
  assign res_o.is_full     = res.is_full;
  assign res_o.is_empty    = res.is_empty;

endmodule

// ----- rtl/bal_checker.sv -----
// port-level checks of the bounded array list and their bind to the top level
// depends on bal_pkg and bounded_array_list
module bal_checker import bal_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       cfg_valid_i,
  input logic       cfg_ready_i,
  input logic [4:0] cfg_cap_i,
  input logic       done_res_i,
  input logic [4:0] removed_i,
  input logic [4:0] length_i,
  input logic       is_full_i,
  input logic       is_empty_i
);

  logic [1:0] pend_q;
  logic [4:0] cap_q;
  int         eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cap_q  <= CAP_RESET;
    end else begin
      pend_q <= pend_q + 2'(in_valid_i && in_ready_i) - 2'(out_valid_i && out_ready_i);
      if (cfg_valid_i && cfg_ready_i) cap_q <= cfg_cap_i;
    end
  end

  always_comb begin
    if (cap_q == 5'd0) eff = 1;
    else if (int'(cap_q) > DEPTH) eff = DEPTH;
    else eff = int'(cap_q);
  end

  // a shown result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(length_i) && $stable(removed_i))
    else $error("result dropped or changed while stalled");

  // at most one result waiting plus one request in work, never a result from nothing
  a_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q != 2'd3) && (!out_valid_i || pend_q != 2'd0))
    else $error("requests and results out of balance");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> is_empty_i == (length_i == 5'd0))
    else $error("empty flag disagrees with length");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> is_full_i == (int'(length_i) >= eff))
    else $error("full flag disagrees with capacity");

  a_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && removed_i != 5'd0 |-> done_res_i)
    else $error("entries removed without done");

endmodule

bind bounded_array_list bal_checker #(
  .DEPTH (DEPTH)
) u_bal_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready),
  .cfg_cap_i   (cfg_i.capacity),
  .done_res_i  (res_o.done_res),
  .removed_i   (res_o.removed),
  .length_i    (res_o.length),
  .is_full_i   (res_o.is_full),
  .is_empty_i  (res_o.is_empty)
);

// ----- dv/tb_bounded_array_list.sv -----
// self-checking testbench for the bounded array list top level
// needs bal_pkg, the bal_if channel interfaces and the bounded_array_list rtl
module tb_bounded_array_list import bal_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH = DEPTH_DEFAULT;
  // longer than the worst request, so this covers anything still in flight
  localparam int SETTLE_CYCLES = LIST_DEPTH + 16;
  // longest legal quiet stretch is the receiver hold-off plus one request
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_REQUESTS = 155;
  // command codes the block ignores
  localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [2:0] CMD_SPARE_MID = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

  logic clk_i;
  logic rst_ni;

  bal_cmd_if cmd_ch ();
  bal_res_if res_ch ();
  bal_cfg_if cfg_ch ();

  bounded_array_list #(.DEPTH(LIST_DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  // shadow copy of the list, its length and the capacity register
  logic signed [31:0] shadow_words [LIST_DEPTH];
  int                 shadow_len;
  logic [4:0]         shadow_cap;

  // results predicted at request acceptance, oldest first
  res_t pending_res_q [$];

  int err_cnt = 0;
  int idle_cycles = 0;

  // sender and receiver idling controls
  bit gaps_on;
  bit stalls_on;
  int burst_left;
  int hold_left;

  // small pool of words so that remove-value finds matches
  logic signed [31:0] word_pool [4];
  int                 pool_n;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // list predictor: applies one request to the shadow list, returns the result
  // ---------------------------------------------------------------------------
  function automatic res_t apply_list_cmd(logic [2:0] cmd, logic [7:0] pos,
                                          logic signed [31:0] val);
    res_t r;
    int   lim;
    int   at;
    int   j;
    int   keep;
    int   n_del;
    r     = '0;
    n_del = 0;
    // capacity clamps to 1..DEPTH
    if (shadow_cap == 5'd0) lim = 1;
    else if (int'(shadow_cap) > LIST_DEPTH) lim = LIST_DEPTH;
    else lim = int'(shadow_cap);
    case (cmd)
      CMD_APPEND, CMD_INSERT: begin
        // refused when full, including when capacity dropped below length
        if (shadow_len < lim) begin
          at = shadow_len;
          // insert at or past the length degrades to append
          if (cmd == CMD_INSERT && int'(pos) < shadow_len) begin
            at = int'(pos);
            for (j = shadow_len; j > at; j--) shadow_words[j] = shadow_words[j - 1];
          end
          shadow_words[at] = val;
          shadow_len++;
          r.entry_index = 4'(at);
          r.done_res    = 1'b1;
        end
      end
      CMD_REM_IDX: begin
        if (int'(pos) < shadow_len) begin
          for (j = int'(pos); j + 1 < shadow_len; j++) shadow_words[j] = shadow_words[j + 1];
          shadow_len--;
          n_del      = 1;
          r.done_res = 1'b1;
        end
      end
      CMD_REM_VAL: begin
        // drop every match and compact the survivors in order
        keep = 0;
        for (j = 0; j < shadow_len; j++) begin
          if (shadow_words[j] == val) begin
            n_del++;
          end else begin
            shadow_words[keep] = shadow_words[j];
            keep++;
          end
        end
        shadow_len = keep;
        r.done_res = (n_del > 0);
      end
      CMD_READ: begin
        if (int'(pos) < shadow_len) begin
          r.read_word = shadow_words[pos];
          r.done_res  = 1'b1;
        end
      end
      default: ;
    endcase
    r.removed  = 5'(n_del);
    r.length   = 5'(shadow_len);
    r.is_full  = (shadow_len >= lim);
    r.is_empty = (shadow_len == 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: every accepted result against the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch on %s: expected 0x%08h, actual 0x%08h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_res_q.size() == 0) begin
        $display("%0t result with no request outstanding: length %0d", $time,
                 res_ch.length);
        err_cnt++;
      end else begin
        want = pending_res_q.pop_front();
        check_field("done_res",    32'(want.done_res),    32'(res_ch.done_res));
        check_field("entry_index", 32'(want.entry_index), 32'(res_ch.entry_index));
        check_field("read_word",   want.read_word,        res_ch.read_word);
        check_field("removed",     32'(want.removed),     32'(res_ch.removed));
        check_field("length",      32'(want.length),      32'(res_ch.length));
        check_field("is_full",     32'(want.is_full),     32'(res_ch.is_full));
        check_field("is_empty",    32'(want.is_empty),    32'(res_ch.is_empty));
      end
    end
  end

  // watchdog: any handshake on any channel counts as progress
  always @(posedge clk_i) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog expired with %0d results outstanding", $time,
               pending_res_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: long hold-off when asked, else always ready or a rotating stall pattern
  // ---------------------------------------------------------------------------
  initial begin
    int          ph;
    logic [15:0] pat;
    ph           = 0;
    pat          = 16'hffff;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        // hold-off is counted down here, once per falling edge
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (!stalls_on) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= pat[ph];
        ph = (ph + 1) % 16;
        // fresh pattern each time the phase wraps, never all stalls
        if (ph == 0) pat = 16'($urandom) | (16'd1 << $urandom_range(0, 15));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request sender: bursts of random length with random gaps between them
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [2:0] cmd, input logic [7:0] pos,
                              input logic signed [31:0] val);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk_i);
      cmd_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    cmd_ch.valid    <= 1'b1;
    cmd_ch.command  <= cmd;
    cmd_ch.position <= pos;
    cmd_ch.value    <= val;
    do @(posedge clk_i); while (!cmd_ch.ready);
    // predict on acceptance, so the shadow list tracks the block in order
    pending_res_q.push_back(apply_list_cmd(cmd, pos, val));
  endtask

  // stop sending and wait until every predicted result has been checked
  task automatic drain_results();
    @(negedge clk_i);
    cmd_ch.valid <= 1'b0;
    while (pending_res_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // capacity writes only happen with the block idle
  task automatic write_capacity(input logic [4:0] cap);
    drain_results();
    @(negedge clk_i);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.capacity <= cap;
    do @(posedge clk_i); while (!cfg_ch.ready);
    shadow_cap = cap;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // one random request, mostly well-formed positions against the current length
  task automatic send_random_request();
    int                 pick;
    logic [7:0]         pos;
    logic signed [31:0] val;
    pick = $urandom_range(0, 99);
    // positions mostly within the list, sometimes anywhere in the byte
    if ($urandom_range(0, 9) < 8) pos = 8'($urandom_range(0, shadow_len));
    else pos = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 1)) val = word_pool[$urandom_range(0, pool_n - 1)];
    else val = $urandom;
    if (pick < 30) send_request(CMD_APPEND, pos, val);
    else if (pick < 45) send_request(CMD_INSERT, pos, val);
    else if (pick < 58) send_request(CMD_REM_IDX, pos, val);
    else if (pick < 70) send_request(CMD_REM_VAL, pos, val);
    else if (pick < 92) send_request(CMD_READ, pos, val);
    else send_request(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), pos, val);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // read and both removes on an empty list, plus the unused codes
  task automatic test_empty_list();
    send_request(CMD_READ, 8'd0, 32'sd0);
    send_request(CMD_REM_IDX, 8'd0, 32'sd0);
    send_request(CMD_REM_VAL, 8'd0, 32'sd0);
    send_request(CMD_SPARE_LO, 8'd0, 32'sd0);
    send_request(CMD_SPARE_MID, 8'd255, -32'sd1);
    send_request(CMD_SPARE_HI, 8'd128, 32'sd1);
  endtask

  // extreme words, insert placement, out-of-range indexes, multi-match removal
  task automatic test_edge_values();
    send_request(CMD_APPEND, 8'd0, 32'sh7fffffff);
    send_request(CMD_APPEND, 8'd0, 32'sh80000000);
    send_request(CMD_APPEND, 8'd0, -32'sd1);
    send_request(CMD_APPEND, 8'd0, 32'sd0);
    send_request(CMD_APPEND, 8'd0, 32'sd9);
    send_request(CMD_APPEND, 8'd0, 32'sd9);
    // insert at the head shifts everything up
    send_request(CMD_INSERT, 8'd0, 32'sd5);
    // insert far past the end and at the length both append
    send_request(CMD_INSERT, 8'd255, 32'sd7);
    send_request(CMD_INSERT, 8'(shadow_len), 32'sd11);
    send_request(CMD_READ, 8'd255, 32'sd0);
    send_request(CMD_READ, 8'd0, 32'sd0);
    send_request(CMD_READ, 8'(shadow_len - 1), 32'sd0);
    send_request(CMD_REM_IDX, 8'd255, 32'sd0);
    send_request(CMD_REM_IDX, 8'd0, 32'sd0);
    // two matches at once, then a miss
    send_request(CMD_REM_VAL, 8'd0, 32'sd9);
    send_request(CMD_REM_VAL, 8'd0, 32'sd12345);
  endtask

  // capacity zero below the length refuses adds; capacity above depth acts as depth
  task automatic test_capacity_limits();
    write_capacity(5'd0);
    send_request(CMD_APPEND, 8'd0, 32'sd3);
    send_request(CMD_INSERT, 8'd0, 32'sd4);
    write_capacity(5'd31);
    send_request(CMD_APPEND, 8'd0, 32'sd3);
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    int n;
    write_capacity(5'd16);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    hold_left = HOLD_CYCLES;
    for (n = 0; n < 60; n++) send_random_request();
    // sender pauses until every result is back
    drain_results();
  endtask

  // random mix over a sweep of capacities, idling style changing per phase
  task automatic test_random_mix();
    logic [4:0] cap_sweep [10];
    int         p;
    int         n;
    cap_sweep = '{5'd1, 5'd16, 5'd3, 5'd0, 5'd31, 5'd8, 5'd17, 5'd2, 5'd12, 5'd16};
    for (p = 0; p < 10; p++) begin
      // random capacity in the last phase can be any register bit pattern
      if (p == 9) write_capacity(5'($urandom_range(0, 31)));
      else write_capacity(cap_sweep[p]);
      gaps_on   = (p % 3 != 1);
      stalls_on = (p % 3 == 0);
      // a single-word pool lets remove-value clear a full list at once
      pool_n = (p == 1) ? 1 : 4;
      word_pool[0] = $urandom;
      word_pool[1] = $urandom;
      word_pool[2] = 32'sh7fffffff;
      word_pool[3] = 32'sh80000000;
      for (n = 0; n < PHASE_REQUESTS; n++) send_random_request();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    gaps_on         = 1'b1;
    stalls_on       = 1'b1;
    burst_left      = 0;
    hold_left       = 0;
    pool_n          = 4;
    word_pool       = '{default: '0};
    shadow_words    = '{default: '0};
    shadow_len      = 0;
    shadow_cap      = CAP_RESET;
    cmd_ch.valid    = 1'b0;
    cmd_ch.command  = CMD_APPEND;
    cmd_ch.position = '0;
    cmd_ch.value    = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.capacity = '0;
    rst_ni          = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_list();
    test_edge_values();
    test_capacity_limits();
    test_backpressure();
    test_random_mix();

    drain_results();
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bal_pkg.sv
rtl/bal_if.sv
rtl/bal_ctrl.sv
rtl/bal_dp.sv
rtl/bounded_array_list.sv
rtl/bal_checker.sv
dv/tb_bounded_array_list.sv
